>>> rtl/hurwitz_class_number_count_assert.svh
// Assertion macros for the Hurwitz class number counter.
// Included by the top level; depends on nothing else.
`ifndef HURWITZ_CLASS_NUMBER_COUNT_ASSERT_SVH
`define HURWITZ_CLASS_NUMBER_COUNT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HCNC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hcnc: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define HCNC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hcnc: next-cycle check failed");

`endif

>>> rtl/hcnc_pkg.sv
// Shared types, constants and the microcode table of the class number counter.
// Used by the top level, the sequencer and the datapath; depends on nothing.
`default_nettype none

package hcnc_pkg;

    localparam int DISC_BITS_DEF = 19;
    localparam int OUT_W         = 24;
    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    localparam int STEP_W = 5;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,       // take d, clear count and square flag
        OP_INIT_B,     // b = parity of d, b2 = (d+1)/4, a = 1
        OP_MUL_A,      // prod = a*a
        OP_MUL_B,      // prod = b*b
        OP_MOD_A,      // start b2 mod a
        OP_MOD_B,      // start b2 mod b
        OP_CNT_EVEN,   // h += 1 on divisor, a++
        OP_SET_SQ,     // sq = (prod == b2), b = 2, b2 = (d+4)/4
        OP_CNT_B,      // h += 1 on divisor, a = b+1
        OP_CNT_ODD_A,  // h += 2 on divisor, a++
        OP_CNT_SQ,     // h += 1 on exact root, b += 2
        OP_NEXT_B2,    // b2 = (prod + d)/4
        OP_FINAL,      // scale count into the result
        OP_SET_BAD,    // flag a bad residue
        OP_EMIT        // hand the result to the output register
    } t_op;

    typedef enum logic [3:0] {
        C_NONE,
        C_ALWAYS,
        C_NO_IN,
        C_INVALID,
        C_ODD,
        C_AA_GE,
        C_MOD_BUSY,
        C_B3_GE,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op                op;
        t_cond              cond;
        logic [STEP_W-1:0]  target;
    } t_uword;

    typedef struct packed {
        logic invalid;
        logic odd;
        logic aa_ge;
        logic mod_busy;
        logic b3_ge;
    } t_dp_flags;

    typedef struct packed {
        t_dp_flags dp;
        logic      in_valid;
        logic      out_busy;
    } t_cond_in;

    typedef struct packed {
        t_op  op;
        logic idle;
    } t_ctrl;

    // Program step addresses.
    localparam logic [STEP_W-1:0] S_IDLE   = 5'd0;
    localparam logic [STEP_W-1:0] S_CHECK  = 5'd1;
    localparam logic [STEP_W-1:0] S_INIT   = 5'd2;
    localparam logic [STEP_W-1:0] S_E_MUL  = 5'd3;
    localparam logic [STEP_W-1:0] S_E_TEST = 5'd4;
    localparam logic [STEP_W-1:0] S_E_MOD  = 5'd5;
    localparam logic [STEP_W-1:0] S_E_WAIT = 5'd6;
    localparam logic [STEP_W-1:0] S_E_CNT  = 5'd7;
    localparam logic [STEP_W-1:0] S_E_END  = 5'd8;
    localparam logic [STEP_W-1:0] S_O_TEST = 5'd9;
    localparam logic [STEP_W-1:0] S_B_MOD  = 5'd10;
    localparam logic [STEP_W-1:0] S_B_WAIT = 5'd11;
    localparam logic [STEP_W-1:0] S_B_CNT  = 5'd12;
    localparam logic [STEP_W-1:0] S_A_MUL  = 5'd13;
    localparam logic [STEP_W-1:0] S_A_TEST = 5'd14;
    localparam logic [STEP_W-1:0] S_A_MOD  = 5'd15;
    localparam logic [STEP_W-1:0] S_A_WAIT = 5'd16;
    localparam logic [STEP_W-1:0] S_A_CNT  = 5'd17;
    localparam logic [STEP_W-1:0] S_A_END  = 5'd18;
    localparam logic [STEP_W-1:0] S_B_MUL  = 5'd19;
    localparam logic [STEP_W-1:0] S_B_NEXT = 5'd20;
    localparam logic [STEP_W-1:0] S_FINAL  = 5'd21;
    localparam logic [STEP_W-1:0] S_EMIT   = 5'd22;
    localparam logic [STEP_W-1:0] S_DONE   = 5'd23;
    localparam logic [STEP_W-1:0] S_BAD    = 5'd24;

    // Microcode: take the jump when the condition holds, else fall through.
    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        case (step)
            S_IDLE:   w = '{OP_LOAD,      C_NO_IN,    S_IDLE};
            S_CHECK:  w = '{OP_NOP,       C_INVALID,  S_BAD};
            S_INIT:   w = '{OP_INIT_B,    C_ODD,      S_O_TEST};
            S_E_MUL:  w = '{OP_MUL_A,     C_NONE,     S_IDLE};
            S_E_TEST: w = '{OP_NOP,       C_AA_GE,    S_E_END};
            S_E_MOD:  w = '{OP_MOD_A,     C_NONE,     S_IDLE};
            S_E_WAIT: w = '{OP_NOP,       C_MOD_BUSY, S_E_WAIT};
            S_E_CNT:  w = '{OP_CNT_EVEN,  C_ALWAYS,   S_E_MUL};
            S_E_END:  w = '{OP_SET_SQ,    C_NONE,     S_IDLE};
            S_O_TEST: w = '{OP_NOP,       C_B3_GE,    S_FINAL};
            S_B_MOD:  w = '{OP_MOD_B,     C_NONE,     S_IDLE};
            S_B_WAIT: w = '{OP_NOP,       C_MOD_BUSY, S_B_WAIT};
            S_B_CNT:  w = '{OP_CNT_B,     C_NONE,     S_IDLE};
            S_A_MUL:  w = '{OP_MUL_A,     C_NONE,     S_IDLE};
            S_A_TEST: w = '{OP_NOP,       C_AA_GE,    S_A_END};
            S_A_MOD:  w = '{OP_MOD_A,     C_NONE,     S_IDLE};
            S_A_WAIT: w = '{OP_NOP,       C_MOD_BUSY, S_A_WAIT};
            S_A_CNT:  w = '{OP_CNT_ODD_A, C_ALWAYS,   S_A_MUL};
            S_A_END:  w = '{OP_CNT_SQ,    C_NONE,     S_IDLE};
            S_B_MUL:  w = '{OP_MUL_B,     C_NONE,     S_IDLE};
            S_B_NEXT: w = '{OP_NEXT_B2,   C_ALWAYS,   S_O_TEST};
            S_FINAL:  w = '{OP_FINAL,     C_NONE,     S_IDLE};
            S_EMIT:   w = '{OP_EMIT,      C_OUT_BUSY, S_EMIT};
            S_DONE:   w = '{OP_NOP,       C_ALWAYS,   S_IDLE};
            S_BAD:    w = '{OP_SET_BAD,   C_ALWAYS,   S_EMIT};
            default:  w = '{OP_NOP,       C_ALWAYS,   S_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> rtl/hurwitz_class_number_count.sv
// Top level of the Hurwitz class number counter: sequencer, datapath, output register.
// Depends on hcnc_pkg, hcnc_seq, hcnc_dp and the assertion macro header.
//
// Use: send a discriminant magnitude d on the slave stream (one beat = one d in the
// low DISC_BITS bits of i_s_tdata, higher bits ignored). One result beat follows on
// the master stream: o_m_tdata carries six times the Hurwitz class number H(d),
// saturated at 24 bits, and o_m_tuser flags d of residue 1 or 2 mod 4 (value 0 then).
// o_s_tready is high only while the sequencer sits at its idle step, so one d is
// worked on at a time; the result register lets the next d enter while the previous
// result still waits for i_m_tready.
// The work is a pair of nested loops over b and over trial divisors a. Each trial
// steps through multiply, compare, start, a wait on the bit-serial remainder unit
// and count. A bad residue skips the loops and goes from the check step through
// the bad-residue step to the emit step.
// Reset (synchronous, active low) returns the sequencer to its idle step, holds
// o_s_tready low and drops o_m_tvalid. When the receiver stalls, the result holds in
// the output register and the sequencer waits at its emit step until the register frees.
`default_nettype none
`include "hurwitz_class_number_count_assert.svh"

module hurwitz_class_number_count
    import hcnc_pkg::*;
#(
    parameter int DISC_BITS = DISC_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // slave stream: [DISC_BITS-1:0] d_value, zero padding above
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire logic [((DISC_BITS+7)/8)*8-1:0]  i_s_tdata,
    // master stream: [23:0] class_times_six
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic [OUT_W-1:0]                     o_m_tdata,
    // master stream: [0] status
    output logic                                 o_m_tuser
);

    t_ctrl            ctrl;
    t_dp_flags        dp_flags;
    t_cond_in         cond;
    logic             s_fire;
    logic             out_busy;
    logic             emit_fire;
    logic [OUT_W-1:0] dp_result;
    logic             dp_status;

    logic             r_m_tvalid;
    logic [OUT_W-1:0] r_m_tdata;
    logic             r_m_tuser;

    // accept only at the idle step of the program, never during reset
    assign o_s_tready = (ctrl.op == OP_LOAD) && i_rst_n;
    assign s_fire     = i_s_tvalid && o_s_tready;

    // output register is busy when it holds a beat the receiver does not take now
    assign out_busy  = r_m_tvalid && !i_m_tready;
    assign emit_fire = (ctrl.op == OP_EMIT) && !out_busy;

    assign cond.dp       = dp_flags;
    assign cond.in_valid = i_s_tvalid;
    assign cond.out_busy = out_busy;

    hcnc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cond  (cond),
        .o_ctrl  (ctrl)
    );

    hcnc_dp #(
        .DISC_BITS (DISC_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (ctrl.op),
        .i_load   (s_fire),
        .i_d      (i_s_tdata[DISC_BITS-1:0]),
        .o_flags  (dp_flags),
        .o_result (dp_result),
        .o_status (dp_status)
    );

    // result register: load on emit, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (emit_fire) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
        if (emit_fire) begin
            r_m_tdata <= dp_result;
            r_m_tuser <= dp_status;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

    // an accepted beat always moves the program off its idle step
    `HCNC_ASSERT_NEXT(a_leave_idle, i_clk, i_rst_n, s_fire, !ctrl.idle)
    // an emit always presents a result beat in the next cycle
    `HCNC_ASSERT_NEXT(a_emit_shows, i_clk, i_rst_n, emit_fire, o_m_tvalid)
    // while the remainder unit runs, the program issues only no-op steps
    `HCNC_ASSERT_NOW(a_mod_wait, i_clk, i_rst_n, dp_flags.mod_busy, ctrl.op == OP_NOP)

endmodule

`default_nettype wire

>>> rtl/hcnc_mod.sv
// Bit-serial remainder unit: one dividend bit per cycle, restoring form.
// Depends on nothing beyond its parameters.
`default_nettype none

module hcnc_mod #(
    parameter int N_W = 20,
    parameter int M_W = 11
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [N_W-1:0] i_dividend,
    input  wire logic [M_W-1:0] i_divisor,
    output logic                o_busy,
    output logic                o_rem_zero
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [N_W-1:0]   r_dvd, n_dvd;
    logic [M_W-1:0]   r_div, n_div;
    logic [M_W-1:0]   r_rem, n_rem;
    logic [M_W:0]     trial;

    always_comb begin
        n_cnt = r_cnt;
        n_dvd = r_dvd;
        n_div = r_div;
        n_rem = r_rem;
        trial = {r_rem, r_dvd[N_W-1]};
        if (i_start) begin
            n_cnt = CNT_W'(N_W);
            n_dvd = i_dividend;
            n_div = i_divisor;
            n_rem = '0;
        end else if (r_cnt != '0) begin
            // shift in the next bit, subtract when it fits
            if (trial >= {1'b0, r_div}) begin
                n_rem = M_W'(trial - {1'b0, r_div});
            end else begin
                n_rem = M_W'(trial);
            end
            n_dvd = {r_dvd[N_W-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_div <= n_div;
        r_rem <= n_rem;
    end

    assign o_busy     = (r_cnt != '0);
    assign o_rem_zero = (r_rem == '0);

endmodule

`default_nettype wire

>>> rtl/hcnc_dp.sv
// Datapath of the class number counter: d, b, b2, a, count, one multiplier.
// Depends on hcnc_pkg and hcnc_mod.
`default_nettype none

module hcnc_dp
    import hcnc_pkg::*;
#(
    parameter int DISC_BITS = DISC_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_op                  i_op,
    input  wire logic                 i_load,
    input  wire logic [DISC_BITS-1:0] i_d,
    output t_dp_flags                 o_flags,
    output logic [OUT_W-1:0]          o_result,
    output logic                      o_status
);

    localparam int D_W  = DISC_BITS;
    localparam int B2_W = D_W + 1;
    localparam int B_W  = D_W / 2 + 2;
    localparam int P_W  = 2 * B_W;

    logic [D_W-1:0]   r_d, n_d;
    logic [B_W-1:0]   r_b, n_b;
    logic [B_W-1:0]   r_a, n_a;
    logic [B2_W-1:0]  r_b2, n_b2;
    logic [P_W-1:0]   r_prod, n_prod;
    logic [OUT_W-1:0] r_h, n_h;
    logic             r_sq, n_sq;
    logic [OUT_W-1:0] r_res, n_res;
    logic             r_status, n_status;

    logic [B_W-1:0]   mul_op;
    logic [B_W-1:0]   mod_div;
    logic             mod_start;
    logic             mod_busy;
    logic             rem_zero;
    logic [B2_W+1:0]  b2_x3;
    logic             b3_eq;
    logic             root_eq;
    logic [1:0]       h_inc;
    logic [OUT_W:0]   h_sum;
    logic [OUT_W+2:0] scaled;
    logic [D_W:0]     d_p1;
    logic [D_W:0]     d_p4;
    logic [P_W:0]     sq_sum;

    assign mod_start = (i_op == OP_MOD_A) || (i_op == OP_MOD_B);
    assign mod_div   = (i_op == OP_MOD_B) ? r_b : r_a;
    assign mul_op    = (i_op == OP_MUL_B) ? r_b : r_a;

    hcnc_mod #(
        .N_W (B2_W),
        .M_W (B_W)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (r_b2),
        .i_divisor  (mod_div),
        .o_busy     (mod_busy),
        .o_rem_zero (rem_zero)
    );

    assign b2_x3   = (B2_W + 2)'({r_b2, 1'b0}) + (B2_W + 2)'(r_b2);
    assign b3_eq   = (b2_x3 == (B2_W + 2)'(r_d));
    assign root_eq = (r_prod == P_W'(r_b2));
    assign d_p1    = (D_W + 1)'(r_d) + (D_W + 1)'(1);
    assign d_p4    = (D_W + 1)'(r_d) + (D_W + 1)'(4);
    assign sq_sum  = (P_W + 1)'(r_prod) + (P_W + 1)'(r_d);

    assign o_flags.invalid  = (r_d[1:0] == 2'd1) || (r_d[1:0] == 2'd2);
    assign o_flags.odd      = r_d[0];
    assign o_flags.aa_ge    = (r_prod >= P_W'(r_b2));
    assign o_flags.mod_busy = mod_busy;
    assign o_flags.b3_ge    = (b2_x3 >= (B2_W + 2)'(r_d));

    always_comb begin
        h_inc = 2'd0;
        case (i_op)
            OP_CNT_EVEN:  h_inc = {1'b0, rem_zero};
            OP_CNT_B:     h_inc = {1'b0, rem_zero};
            OP_CNT_ODD_A: h_inc = {rem_zero, 1'b0};
            OP_CNT_SQ:    h_inc = {1'b0, root_eq};
            default:      h_inc = 2'd0;
        endcase
        h_sum = (OUT_W + 1)'(r_h) + (OUT_W + 1)'(h_inc);
    end

    // 6*h plus the end adjustment
    assign scaled = (OUT_W + 3)'({r_h, 2'b00}) + (OUT_W + 3)'({r_h, 1'b0})
                  + (b3_eq ? (OUT_W + 3)'(2) : (r_sq ? (OUT_W + 3)'(3) : '0));

    always_comb begin
        n_d      = r_d;
        n_b      = r_b;
        n_a      = r_a;
        n_b2     = r_b2;
        n_prod   = r_prod;
        n_h      = r_h;
        n_sq     = r_sq;
        n_res    = r_res;
        n_status = r_status;
        case (i_op)
            OP_LOAD: begin
                if (i_load) begin
                    n_d  = i_d;
                    n_h  = '0;
                    n_sq = 1'b0;
                end
            end
            OP_INIT_B: begin
                n_b  = B_W'(r_d[0]);
                n_b2 = B2_W'(d_p1[D_W:2]);
                n_a  = B_W'(1);
            end
            OP_MUL_A, OP_MUL_B: begin
                n_prod = P_W'(mul_op) * P_W'(mul_op);
            end
            OP_CNT_EVEN, OP_CNT_ODD_A: begin
                n_a = r_a + B_W'(1);
            end
            OP_CNT_B: begin
                n_a = r_b + B_W'(1);
            end
            OP_CNT_SQ: begin
                n_b = r_b + B_W'(2);
            end
            OP_SET_SQ: begin
                n_sq = root_eq;
                n_b  = B_W'(2);
                n_b2 = B2_W'(d_p4[D_W:2]);
            end
            OP_NEXT_B2: begin
                n_b2 = sq_sum[B2_W+1:2];
            end
            OP_FINAL: begin
                n_res    = (scaled > (OUT_W + 3)'(OUT_MAX)) ? OUT_MAX : OUT_W'(scaled);
                n_status = 1'b0;
            end
            OP_SET_BAD: begin
                n_res    = '0;
                n_status = 1'b1;
            end
            default: begin
            end
        endcase
        // saturating count; any count this large saturates the result anyway
        if (h_inc != 2'd0) begin
            n_h = (h_sum > (OUT_W + 1)'(OUT_MAX)) ? OUT_MAX : OUT_W'(h_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        r_d      <= n_d;
        r_b      <= n_b;
        r_a      <= n_a;
        r_b2     <= n_b2;
        r_prod   <= n_prod;
        r_h      <= n_h;
        r_sq     <= n_sq;
        r_res    <= n_res;
        r_status <= n_status;
    end

    assign o_result = r_res;
    assign o_status = r_status;

endmodule

`default_nettype wire

>>> rtl/hcnc_seq.sv
// Microcode sequencer: step counter, program table, conditional jumps.
// Depends on hcnc_pkg.
`default_nettype none

module hcnc_seq
    import hcnc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cond_in i_cond,
    output t_ctrl         o_ctrl
);

    logic [STEP_W-1:0] r_pc, n_pc;
    t_uword            uw;
    logic              take;

    assign uw = ucode(r_pc);

    always_comb begin
        case (uw.cond)
            C_NONE:     take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NO_IN:    take = !i_cond.in_valid;
            C_INVALID:  take = i_cond.dp.invalid;
            C_ODD:      take = i_cond.dp.odd;
            C_AA_GE:    take = i_cond.dp.aa_ge;
            C_MOD_BUSY: take = i_cond.dp.mod_busy;
            C_B3_GE:    take = i_cond.dp.b3_ge;
            C_OUT_BUSY: take = i_cond.out_busy;
            default:    take = 1'b0;
        endcase
        n_pc = take ? uw.target : r_pc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl.op   = uw.op;
    assign o_ctrl.idle = (r_pc == S_IDLE);

endmodule

`default_nettype wire

>>> verif/hcnc_class_checker.sv
`timescale 1ns / 1ps
// Checker for the Hurwitz class number counter: watches both stream channels,
// predicts each result from the accepted d and compares it in order.
// Depends on hcnc_pkg for the result width and saturation value.

module hcnc_class_checker
    import hcnc_pkg::*;
#(
    parameter int DISC_BITS = DISC_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    input  wire logic                            i_s_tready,
    input  wire logic [((DISC_BITS+7)/8)*8-1:0]  i_s_tdata,
    input  wire logic                            i_m_tvalid,
    input  wire logic                            i_m_tready,
    input  wire logic [OUT_W-1:0]                i_m_tdata,
    input  wire logic                            i_m_tuser,
    output int                                   o_mismatches,
    output int                                   o_pending
);

    localparam logic       STATUS_OK          = 1'b0;
    localparam logic       STATUS_BAD_RESIDUE = 1'b1;
    localparam logic [1:0] RESIDUE_ONE        = 2'd1;
    localparam logic [1:0] RESIDUE_TWO        = 2'd2;
    localparam int         REPORT_LIMIT       = 10;

    typedef struct packed {
        logic [DISC_BITS-1:0] disc;
        logic [OUT_W-1:0]     class_times_six;
        logic                 status;
    } t_class_beat;

    t_class_beat class_results_q[$];

    // Count reduced forms of discriminant -d and scale by six, with the
    // corrections for the form with a == b == c and for the square d/4.
    function automatic longint unsigned six_times_class(input longint unsigned d);
        longint unsigned h, a, b, b2;
        bit              sq;
        h  = 0;
        sq = 1'b0;
        b  = d & 1;
        b2 = (d + 1) >> 2;
        if (b == 0) begin
            for (a = 1; a * a < b2; a = a + 1)
                if (b2 % a == 0) h = h + 1;
            sq = (a * a == b2);
            b  = 2;
            b2 = (d + 4) >> 2;
        end
        while (b2 * 3 < d) begin
            if (b2 % b == 0) h = h + 1;
            for (a = b + 1; a * a < b2; a = a + 1)
                if (b2 % a == 0) h = h + 2;
            if (a * a == b2) h = h + 1;
            b  = b + 2;
            b2 = (b * b + d) >> 2;
        end
        if (b2 * 3 == d) return 6 * h + 2;
        if (sq) return 6 * h + 3;
        return 6 * h;
    endfunction

    function automatic t_class_beat predict_class(input logic [DISC_BITS-1:0] disc);
        t_class_beat     r;
        longint unsigned v;
        r.disc = disc;
        if (disc[1:0] == RESIDUE_ONE || disc[1:0] == RESIDUE_TWO) begin
            r.class_times_six = '0;
            r.status          = STATUS_BAD_RESIDUE;
        end else begin
            v = six_times_class(longint'(disc));
            if (v > OUT_MAX) v = OUT_MAX;
            r.class_times_six = v[OUT_W-1:0];
            r.status          = STATUS_OK;
        end
        return r;
    endfunction

    task automatic note_mismatch(input string msg);
        if (o_mismatches < REPORT_LIMIT) $display("mismatch: %s", msg);
        o_mismatches = o_mismatches + 1;
    endtask

    always @(posedge i_clk) begin : watch
        t_class_beat want;
        if (i_rst_n) begin
            // retire the output beat first: it can never belong to a d taken this edge
            if (i_m_tvalid && i_m_tready) begin
                if (class_results_q.size() == 0) begin
                    note_mismatch($sformatf("unexpected beat value=%0d status=%0d",
                                            i_m_tdata, i_m_tuser));
                end else begin
                    want = class_results_q.pop_front();
                    if (want.class_times_six !== i_m_tdata || want.status !== i_m_tuser)
                        note_mismatch($sformatf("d=%0d expected %0d/%0d got %0d/%0d",
                                                want.disc, want.class_times_six,
                                                want.status, i_m_tdata, i_m_tuser));
                end
            end
            if (i_s_tvalid && i_s_tready)
                class_results_q.push_back(predict_class(i_s_tdata[DISC_BITS-1:0]));
        end
        o_pending = class_results_q.size();
    end

endmodule

>>> verif/tb_hurwitz_class_number_count.sv
`timescale 1ns / 1ps
// Testbench top for the Hurwitz class number counter: clock, reset, d stimulus,
// random back-pressure and the verdict. Depends on hcnc_pkg and hcnc_class_checker.

module tb_hurwitz_class_number_count
    import hcnc_pkg::*;
;

    localparam int DISC_W = DISC_BITS_DEF;
    localparam int S_W    = ((DISC_W + 7) / 8) * 8;
    localparam int RANDOM_PER_PHASE = 19;
    localparam int DRAIN_CYCLES     = 200;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [S_W-1:0]    s_tdata = '0;     // [18:0] d_value, [23:19] random padding (ignored)
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;          // [23:0] class_times_six
    logic              m_tuser;          // [0] status

    int mismatches;
    int pending;

    // Percent of cycles in which the sender idles / the receiver stalls.
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    hurwitz_class_number_count uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    hcnc_class_checker #(.DISC_BITS(DISC_W)) checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // Receiver: stall at random according to the current phase.
    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Offer one d beat, with random idle cycles ahead of it, and hold it until taken.
    // Sample tready at the falling edge so the handshake is read race free.
    task automatic send_disc(input logic [DISC_W-1:0] d);
        logic [S_W-1:0] word;
        word = S_W'($urandom);          // random padding: the block must ignore it
        word[DISC_W-1:0] = d;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(negedge clk); while (!s_tready);
        @(posedge clk);
    endtask

    // Hold off the sender until every expected result beat has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    // Mostly well-formed d of residue 0 or 3, mostly small so the run stays short;
    // some of residue 1 or 2 over the full range to toggle every bit cheaply.
    function automatic logic [DISC_W-1:0] random_disc();
        logic [DISC_W-1:0] d;
        int                pick;
        pick = $urandom_range(99);
        if (pick < 12) begin
            d      = DISC_W'($urandom);
            d[1:0] = $urandom_range(1) ? 2'd1 : 2'd2;
        end else begin
            d      = (pick < 32) ? DISC_W'($urandom_range(8191))
                                 : DISC_W'($urandom_range(1023));
            d[1:0] = $urandom_range(1) ? 2'd3 : 2'd0;
        end
        return d;
    endfunction

    logic [DISC_W-1:0] directed_d[$] = '{
        0,          // zero input, valid and zero
        3,          // smallest odd d, lone form with a == b == c
        4,          // d/4 a perfect square
        1, 2,       // bad residues
        5, 6,
        7, 8, 11,
        12,         // equilateral form at b = 2
        16, 27, 48, 100, 300,
        1024,       // square d/4 with several divisors
        4095, 4096,
        65535,
        524285,     // bad residues with every high bit set
        524286,
        524287      // largest d: the long haul
    };

    initial begin
        int phase;
        int n;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin sender_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            if (phase == 0)
                foreach (directed_d[i]) send_disc(directed_d[i]);
            for (n = 0; n < RANDOM_PER_PHASE; n++) send_disc(random_disc());
            // pause the sender until the block and the result register are empty
            wait_drained();
        end

        // let any stray beat show up before the verdict
        recv_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Give up well past the slowest correct run (the largest d dominates it).
    initial begin
        #50_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
